### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the point-to-line distance core.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PTL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset
`define PTL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/ptl_pkg.sv
// Shared types and constants of the point-to-line distance core.
// No dependencies; used by the front end, the root cells and the top level.
package ptl_pkg;

    // Width of the unsigned Q18.16 distance
    localparam int DIST_BITS = 34;
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    // Configuration register indexes
    localparam logic [2:0] REG_BASE_X    = 3'd0;
    localparam logic [2:0] REG_BASE_Y    = 3'd1;
    localparam logic [2:0] REG_BASE_Z    = 3'd2;
    localparam logic [2:0] REG_HEADING_X = 3'd3;
    localparam logic [2:0] REG_HEADING_Y = 3'd4;
    localparam logic [2:0] REG_HEADING_Z = 3'd5;

    // Per-stage control that travels with each item
    typedef struct packed {
        logic valid;
        logic degen;
    } ptl_ctl_t;

endpackage

### rtl/core/point_to_line_distance_3d_core.sv
// Top level of the point-to-line distance core: registers, front pipeline, root cells.
// Depends on ptl_pkg, ptl_front, ptl_cell and assert_macros.svh.
//
// Usage:
//   Write the base point and direction through cfg_we/cfg_index/cfg_data
//   (index 0..5: base x,y,z, heading x,y,z) while no item is in flight.
//   Query points enter on the s_axis channel, one per transfer; each gives
//   exactly one result on the m_axis channel: the distance (unsigned Q18.16
//   at the default width) in tdata and the zero-direction flag in tuser.
// Throughput: one item per cycle while the receiver takes results, fully pipelined.
// Pipeline: 6 front stages plus COORD_WIDTH+2 root cells; each root cell
//   settles one bit of the square root.
// Reset clears the pipeline; base resets to the origin and the direction to
//   one unit along x.
// When the receiver stalls, the whole pipeline holds and s_axis_tready drops
//   in the same cycle; nothing is dropped or repeated.
module point_to_line_distance_3d_core #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_we,
    input  logic [2:0]                            cfg_index,
    input  logic [COORD_WIDTH-1:0]                cfg_data,
    // query input
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // query_x, query_y, query_z from bit 0 up, zero padded to bytes
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // result output
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // distance from bit 0 up, zero padded to bytes
    output logic [((ptl_pkg::DIST_BITS+7)/8)*8-1:0] m_axis_tdata,
    // degenerate
    output logic                                  m_axis_tuser
);

    `include "assert_macros.svh"

    localparam int W    = COORD_WIDTH;
    localparam int NW   = 4 * W + 6;
    localparam int PW   = 3 * W + 2;
    localparam int SW   = W + 2;
    localparam int NC   = W + 2;
    localparam int OW   = (SW > ptl_pkg::DIST_BITS) ? SW : ptl_pkg::DIST_BITS;
    localparam int OTW  = ((ptl_pkg::DIST_BITS + 7) / 8) * 8;

    // configuration registers
    logic [W-1:0] base_x_reg, base_y_reg, base_z_reg;
    logic [W-1:0] heading_x_reg, heading_y_reg, heading_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_x_reg    <= '0;
            base_y_reg    <= '0;
            base_z_reg    <= '0;
            heading_x_reg <= W'(1) << FRAC_BITS;
            heading_y_reg <= '0;
            heading_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ptl_pkg::REG_BASE_X:    base_x_reg    <= cfg_data;
                ptl_pkg::REG_BASE_Y:    base_y_reg    <= cfg_data;
                ptl_pkg::REG_BASE_Z:    base_z_reg    <= cfg_data;
                ptl_pkg::REG_HEADING_X: heading_x_reg <= cfg_data;
                ptl_pkg::REG_HEADING_Y: heading_y_reg <= cfg_data;
                ptl_pkg::REG_HEADING_Z: heading_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: hold everything while the last result waits
    ptl_pkg::ptl_ctl_t ctl_chain [NC+1];
    logic              en;

    assign en            = !ctl_chain[NC].valid || m_axis_tready;
    assign s_axis_tready = en;

    logic [NW-1:0]  rem_chain  [NC+1];
    logic [PW-1:0]  prod_chain [NC+1];
    logic [2*W-1:0] den_chain  [NC+1];
    logic [SW-1:0]  root_chain [NC+1];

    ptl_front #(
        .W (W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .query_x   (s_axis_tdata[W-1:0]),
        .query_y   (s_axis_tdata[2*W-1:W]),
        .query_z   (s_axis_tdata[3*W-1:2*W]),
        .base_x    (base_x_reg),
        .base_y    (base_y_reg),
        .base_z    (base_z_reg),
        .heading_x (heading_x_reg),
        .heading_y (heading_y_reg),
        .heading_z (heading_z_reg),
        .ctl_out   (ctl_chain[0]),
        .num_out   (rem_chain[0]),
        .den_out   (den_chain[0])
    );

    assign prod_chain[0] = '0;
    assign root_chain[0] = '0;

    // row of root cells, most significant bit first
    for (genvar g = 0; g < NC; g++)
    begin : g_cell
        ptl_cell #(
            .W   (W),
            .BIT (NC - 1 - g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctl_in   (ctl_chain[g]),
            .rem_in   (rem_chain[g]),
            .prod_in  (prod_chain[g]),
            .den_in   (den_chain[g]),
            .root_in  (root_chain[g]),
            .ctl_out  (ctl_chain[g+1]),
            .rem_out  (rem_chain[g+1]),
            .prod_out (prod_chain[g+1]),
            .den_out  (den_chain[g+1]),
            .root_out (root_chain[g+1])
        );
    end

    // saturate the root to the distance width
    logic [OW-1:0]                  root_wide;
    logic [ptl_pkg::DIST_BITS-1:0]  distance;

    always_comb
    begin
        root_wide = OW'(root_chain[NC]);
        if (root_wide > OW'(ptl_pkg::DIST_MAX))
        begin
            distance = ptl_pkg::DIST_MAX;
        end
        else
        begin
            distance = root_wide[ptl_pkg::DIST_BITS-1:0];
        end
    end

    assign m_axis_tvalid = ctl_chain[NC].valid;
    assign m_axis_tdata  = OTW'(distance);
    assign m_axis_tuser  = ctl_chain[NC].degen;

    // checks
    `PTL_ASSERT_NOW(a_stall_holds_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    `PTL_ASSERT_NEXT(a_result_holds, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `PTL_ASSERT_NOW(a_degen_unit_den, m_axis_tvalid && m_axis_tuser,
        den_chain[NC] == (2*W)'(1))
    `PTL_ASSERT_NOW(a_root_is_max, m_axis_tvalid,
        (NW+1)'(rem_chain[NC]) < ((NW+1)'(prod_chain[NC]) << 1) + (NW+1)'(den_chain[NC]))

endmodule

### rtl/core/ptl_front.sv
// Front pipeline: offset, cross products, squares, numerator and denominator.
// Depends on ptl_pkg.
module ptl_front #(
    parameter int W = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [W-1:0]             query_x,
    input  logic [W-1:0]             query_y,
    input  logic [W-1:0]             query_z,
    input  logic [W-1:0]             base_x,
    input  logic [W-1:0]             base_y,
    input  logic [W-1:0]             base_z,
    input  logic [W-1:0]             heading_x,
    input  logic [W-1:0]             heading_y,
    input  logic [W-1:0]             heading_z,
    output ptl_pkg::ptl_ctl_t        ctl_out,
    output logic [4*W+5:0]           num_out,
    output logic [2*W-1:0]           den_out
);

    localparam int HW  = W + 1;
    localparam int NW  = 4 * W + 6;
    localparam int SQW = 4 * HW;

    // stage 1: offset d = base - query
    ptl_pkg::ptl_ctl_t        ctl1_reg;
    logic signed [W:0]        d_reg [3];
    logic signed [W-1:0]      h_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg.valid <= in_valid;
            ctl1_reg.degen <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= $signed({base_x[W-1], base_x}) - $signed({query_x[W-1], query_x});
            d_reg[1] <= $signed({base_y[W-1], base_y}) - $signed({query_y[W-1], query_y});
            d_reg[2] <= $signed({base_z[W-1], base_z}) - $signed({query_z[W-1], query_z});
            h_reg[0] <= heading_x;
            h_reg[1] <= heading_y;
            h_reg[2] <= heading_z;
        end
    end

    // stage 2: cross-term products and squares
    ptl_pkg::ptl_ctl_t        ctl2_reg;
    logic signed [2*W:0]      m_reg [6];
    logic signed [2*W-1:0]    hsq_reg [3];
    logic signed [2*W+1:0]    dsq_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '0;
        end
        else if (en)
        begin
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0] <= d_reg[1] * h_reg[2];
            m_reg[1] <= d_reg[2] * h_reg[1];
            m_reg[2] <= d_reg[2] * h_reg[0];
            m_reg[3] <= d_reg[0] * h_reg[2];
            m_reg[4] <= d_reg[0] * h_reg[1];
            m_reg[5] <= d_reg[1] * h_reg[0];
            for (int k = 0; k < 3; k++)
            begin
                hsq_reg[k] <= h_reg[k] * h_reg[k];
                dsq_reg[k] <= d_reg[k] * d_reg[k];
            end
        end
    end

    // stage 3: cross components, magnitude, denominator
    logic signed [2*W+1:0]    c_val [3];
    logic [2*W+1:0]           cabs_reg [3];
    logic [2*W-1:0]           den3_reg;
    logic [2*W+1:0]           dsum3_reg;
    logic [2*W-1:0]           den_sum;
    ptl_pkg::ptl_ctl_t        ctl3_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            c_val[k] = (2*W+2)'(m_reg[2*k]) - (2*W+2)'(m_reg[2*k+1]);
        end
        den_sum = (2*W)'(hsq_reg[0]) + (2*W)'(hsq_reg[1]) + (2*W)'(hsq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl3_reg <= '0;
        end
        else if (en)
        begin
            ctl3_reg.valid <= ctl2_reg.valid;
            ctl3_reg.degen <= (den_sum == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                cabs_reg[k] <= c_val[k][2*W+1] ? (2*W+2)'(-c_val[k]) : (2*W+2)'(c_val[k]);
            end
            den3_reg  <= den_sum;
            dsum3_reg <= (2*W+2)'(dsq_reg[0]) + (2*W+2)'(dsq_reg[1])
                       + (2*W+2)'(dsq_reg[2]);
        end
    end

    // stage 4: partial products of each square, split into halves
    logic [2*HW-1:0]          hi2_reg [3];
    logic [2*HW-1:0]          hl_reg [3];
    logic [2*HW-1:0]          lo2_reg [3];
    logic [2*W-1:0]           den4_reg;
    logic [2*W+1:0]           dsum4_reg;
    ptl_pkg::ptl_ctl_t        ctl4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl4_reg <= '0;
        end
        else if (en)
        begin
            ctl4_reg <= ctl3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                hi2_reg[k] <= (2*HW)'(cabs_reg[k][2*HW-1:HW]) * (2*HW)'(cabs_reg[k][2*HW-1:HW]);
                hl_reg[k]  <= (2*HW)'(cabs_reg[k][2*HW-1:HW]) * (2*HW)'(cabs_reg[k][HW-1:0]);
                lo2_reg[k] <= (2*HW)'(cabs_reg[k][HW-1:0]) * (2*HW)'(cabs_reg[k][HW-1:0]);
            end
            den4_reg  <= den3_reg;
            dsum4_reg <= dsum3_reg;
        end
    end

    // stage 5: recombine each square
    logic [SQW-1:0]           sq_reg [3];
    logic [2*W-1:0]           den5_reg;
    logic [2*W+1:0]           dsum5_reg;
    ptl_pkg::ptl_ctl_t        ctl5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl5_reg <= '0;
        end
        else if (en)
        begin
            ctl5_reg <= ctl4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k] <= {hi2_reg[k], {(2*HW){1'b0}}}
                           + (SQW'(hl_reg[k]) << (HW + 1))
                           + SQW'(lo2_reg[k]);
            end
            den5_reg  <= den4_reg;
            dsum5_reg <= dsum4_reg;
        end
    end

    // stage 6: numerator and effective denominator
    ptl_pkg::ptl_ctl_t        ctl6_reg;
    logic [NW-1:0]            num6_reg;
    logic [2*W-1:0]           den6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl6_reg <= '0;
        end
        else if (en)
        begin
            ctl6_reg <= ctl5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ctl5_reg.degen)
            begin
                num6_reg <= NW'(dsum5_reg);
                den6_reg <= (2*W)'(1);
            end
            else
            begin
                num6_reg <= NW'(sq_reg[0]) + NW'(sq_reg[1]) + NW'(sq_reg[2]);
                den6_reg <= den5_reg;
            end
        end
    end

    assign ctl_out = ctl6_reg;
    assign num_out = num6_reg;
    assign den_out = den6_reg;

endmodule

### rtl/core/ptl_cell.sv
// One root cell: decides one bit of s, the largest s with s*s*den <= num.
// Depends on ptl_pkg.
module ptl_cell #(
    parameter int W   = 32,
    parameter int BIT = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  ptl_pkg::ptl_ctl_t    ctl_in,
    input  logic [4*W+5:0]       rem_in,
    input  logic [3*W+1:0]       prod_in,
    input  logic [2*W-1:0]       den_in,
    input  logic [W+1:0]         root_in,
    output ptl_pkg::ptl_ctl_t    ctl_out,
    output logic [4*W+5:0]       rem_out,
    output logic [3*W+1:0]       prod_out,
    output logic [2*W-1:0]       den_out,
    output logic [W+1:0]         root_out
);

    localparam int NW = 4 * W + 6;
    localparam int PW = 3 * W + 2;
    localparam int SW = W + 2;
    localparam logic [SW-1:0] BIT_MASK = SW'(1) << BIT;

    // rem holds num - s*s*den, prod holds s*den
    logic [NW:0]         delta;
    logic                take;
    ptl_pkg::ptl_ctl_t   ctl_reg;
    logic [NW-1:0]       rem_reg;
    logic [PW-1:0]       prod_reg;
    logic [2*W-1:0]      den_reg;
    logic [SW-1:0]       root_reg;

    // cost of setting this bit: (2*s*2^BIT + 2^(2*BIT)) * den
    always_comb
    begin
        delta = ((NW+1)'(prod_in) << (BIT + 1)) + ((NW+1)'(den_in) << (2 * BIT));
        take  = (delta <= (NW+1)'(rem_in));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    // advance the partial root to the neighbor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= den_in;
            if (take)
            begin
                rem_reg  <= rem_in - delta[NW-1:0];
                prod_reg <= prod_in + (PW'(den_in) << BIT);
                root_reg <= root_in | BIT_MASK;
            end
            else
            begin
                rem_reg  <= rem_in;
                prod_reg <= prod_in;
                root_reg <= root_in;
            end
        end
    end

    assign ctl_out  = ctl_reg;
    assign rem_out  = rem_reg;
    assign prod_out = prod_reg;
    assign den_out  = den_reg;
    assign root_out = root_reg;

endmodule
